// ===== src/elt_pkg.sv =====
// shared types, curve constants and fixed-point helpers for the log transfer curve
package elt_pkg;

   localparam int FRAC_BITS_DEF = 22;
   localparam int LOG_ROUNDS    = 56;
   localparam int EXP_TERMS     = 24;

   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
   localparam logic [63:0] EM2_Q64 = 64'hB7E151628AED2A6A;
   localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
   localparam logic [30:0] OUT_MAX = 31'h7FFFFFFF;

   // item context that travels with every stage
   typedef struct packed {
      logic        mode;
      logic        neg;
      logic        lin;
      logic [4:0]  p;
      logic [63:0] m;
      logic [55:0] acc;
      logic [63:0] res;
      logic [7:0]  nb;
      logic [63:0] t;
      logic [63:0] term;
      logic [63:0] sum;
   } ctx_type;

   // (p + 2^(s-1)) >> s, kept to 64 bits
   function automatic logic [63:0] shr_round(logic [127:0] prod, int unsigned s);
      logic [127:0] sum;
      sum = prod + (128'(1) << (s - 1));
      return 64'(sum >> s);
   endfunction

   // elaboration-time helpers for the curve constants
   function automatic logic [63:0] c_mulshr(logic [63:0] a, logic [63:0] b,
                                            int unsigned s, logic rnd);
      logic [127:0] prod;
      prod = {64'b0, a} * {64'b0, b};
      if (rnd) begin
         prod = prod + (128'(1) << (s - 1));
      end
      return 64'(prod >> s);
   endfunction

   function automatic logic [63:0] c_div_scaled(logic [63:0] a, int unsigned s,
                                                logic [63:0] d);
      logic [63:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         q = {q[62:0], 1'b0};
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      for (int i = 0; i < s; i++) begin
         r = {r[62:0], 1'b0};
         q = {q[62:0], 1'b0};
         if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] c_log2_frac(logic [63:0] m_init);
      logic [63:0] m;
      logic [63:0] acc;
      m = m_init;
      acc = '0;
      for (int i = 0; i < 56; i++) begin
         m = c_mulshr(m, m, 62, 1'b0);
         acc = {acc[62:0], 1'b0};
         if (m[63]) begin
            m = m >> 1;
            acc[0] = 1'b1;
         end
      end
      return acc;
   endfunction

   localparam logic [63:0] C_L10      = (64'(3) << 56) + c_log2_frac(64'(5) << 60);
   localparam logic [63:0] C_LN10_Q60 = c_mulshr(LN2_Q64, C_L10 << 4, 64, 1'b1);
   localparam logic [63:0] C_LOG10E   = c_div_scaled(64'(1), 124, C_LN10_Q60);
   localparam logic [63:0] C_E_Q62    = (64'(2) << 62) + (EM2_Q64 >> 2);
   localparam logic [63:0] C_ET       = c_div_scaled(C_E_Q62, 2, 64'(1000));
   localparam logic [63:0] C_XT       = c_div_scaled(C_LOG10E, 1, 64'(11));
   localparam logic [63:0] C_SLOPE    = c_div_scaled(C_LOG10E, 57, 64'(11) * C_ET);
   localparam logic [63:0] C_ISLOPE   = c_div_scaled(64'(11) * C_ET, 63, C_LOG10E);
   localparam logic [63:0] C_K1       = c_div_scaled(64'(1), 121, 64'(11) * C_L10);
   localparam logic [63:0] C_L10X3    = 64'(3) * C_L10;
   localparam logic [63:0] C_L10X11   = 64'(11) * C_L10;

endpackage

// ===== src/elt_mul.sv =====
// two-stage 64x64 multiplier built from four 32x32 partial products
module elt_mul (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [63:0]      in_a,
   input  logic [63:0]      in_b,
   input  elt_pkg::ctx_type in_ctx,
   output logic             out_valid,
   output logic [127:0]     out_prod,
   output elt_pkg::ctx_type out_ctx
);

   logic             v1_ff, v2_ff;
   logic [63:0]      pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   elt_pkg::ctx_type ctx1_ff, ctx2_ff;
   logic [127:0]     prod_ff, prod_in;

   assign prod_in = {64'b0, pp00_ff} + {32'b0, pp01_ff, 32'b0}
                  + {32'b0, pp10_ff, 32'b0} + {pp11_ff, 64'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= {32'b0, in_a[31:0]} * {32'b0, in_b[31:0]};
         pp01_ff <= {32'b0, in_a[31:0]} * {32'b0, in_b[63:32]};
         pp10_ff <= {32'b0, in_a[63:32]} * {32'b0, in_b[31:0]};
         pp11_ff <= {32'b0, in_a[63:32]} * {32'b0, in_b[63:32]};
         ctx1_ff <= in_ctx;
         prod_ff <= prod_in;
         ctx2_ff <= ctx1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_prod  = prod_ff;
   assign out_ctx   = ctx2_ff;

endmodule

// ===== src/elt_log.sv =====
// log2 fraction by repeated squaring, one multiplier per fraction bit
module elt_log (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  elt_pkg::ctx_type in_ctx,
   output logic             out_valid,
   output elt_pkg::ctx_type out_ctx
);

   logic             vld [0:elt_pkg::LOG_ROUNDS];
   elt_pkg::ctx_type ctx [0:elt_pkg::LOG_ROUNDS];

   assign vld[0] = in_valid;
   assign ctx[0] = in_ctx;

   for (genvar r = 0; r < elt_pkg::LOG_ROUNDS; r++) begin : g_round
      logic             mv;
      logic [127:0]     mp;
      elt_pkg::ctx_type mc;
      logic [63:0]      sq;

      elt_mul u_mul (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(vld[r]), .in_a(ctx[r].m), .in_b(ctx[r].m), .in_ctx(ctx[r]),
         .out_valid(mv), .out_prod(mp), .out_ctx(mc)
      );

      // truncated square, renormalize when it reaches 2
      always_comb begin
         sq = mp[125:62];
         ctx[r+1] = mc;
         ctx[r+1].acc = {mc.acc[54:0], sq[63]};
         ctx[r+1].m = sq[63] ? (sq >> 1) : sq;
      end
      assign vld[r+1] = mv;
   end

   assign out_valid = vld[elt_pkg::LOG_ROUNDS];
   assign out_ctx   = ctx[elt_pkg::LOG_ROUNDS];

endmodule

// ===== src/elt_exp.sv =====
// 2^f by a fixed-length taylor series of exp(f ln2), a product and a reciprocal divide per term
module elt_exp (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  elt_pkg::ctx_type in_ctx,
   output logic             out_valid,
   output elt_pkg::ctx_type out_ctx
);

   logic             vld [0:elt_pkg::EXP_TERMS];
   elt_pkg::ctx_type ctx [0:elt_pkg::EXP_TERMS];

   assign vld[0] = in_valid;
   assign ctx[0] = in_ctx;

   for (genvar k = 0; k < elt_pkg::EXP_TERMS; k++) begin : g_term
      localparam logic [63:0] TermDiv = 64'(k + 1);
      // floor((2^64 - 1) / d), first quotient estimate is at most one low
      localparam logic [63:0] TermRcp = 64'hFFFFFFFFFFFFFFFF / TermDiv;
      logic             mv, qv;
      logic [127:0]     mp, qp;
      elt_pkg::ctx_type mc, mc_in, qc;
      logic [63:0]      q0, rem, nt;

      elt_mul u_mul (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(vld[k]), .in_a(ctx[k].term), .in_b(ctx[k].t), .in_ctx(ctx[k]),
         .out_valid(mv), .out_prod(mp), .out_ctx(mc)
      );

      // raw product parked in term until the quotient is known
      always_comb begin
         mc_in = mc;
         mc_in.term = mp[125:62];
      end

      elt_mul u_rcp (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(mv), .in_a(mp[125:62]), .in_b(TermRcp), .in_ctx(mc_in),
         .out_valid(qv), .out_prod(qp), .out_ctx(qc)
      );

      // one correction step brings the estimate to the floor quotient
      always_comb begin
         q0 = qp[127:64];
         rem = qc.term - 64'(q0 * TermDiv);
         nt = (rem >= TermDiv) ? q0 + 64'(1) : q0;
         ctx[k+1] = qc;
         ctx[k+1].term = nt;
         ctx[k+1].sum = qc.sum + nt;
      end
      assign vld[k+1] = qv;
   end

   assign out_valid = vld[elt_pkg::EXP_TERMS];
   assign out_ctx   = ctx[elt_pkg::EXP_TERMS];

endmodule

// ===== src/erimm_log_transfer_curve_core.sv =====
// top level of the erimm log transfer curve: encode or decode one component per beat
// Takes one pixel component per cycle and returns one converted component per beat, in
// order. The path is an input register, the linear / scale multiply, the ln2 multiply,
// the 24-term exp2 series (per term a product and a reciprocal multiply for the division
// by the term index), the 56 log2 squaring rounds, the output scale multiply and the
// output register. Each multiply is a 64x64 product in two stages of 32x32 partial products.
// Every item walks the full pipeline in both modes, so latency does not depend on data.
// When a result waits at the output and rsp_ready is low the whole pipeline holds;
// req_ready follows that same stall. inverse_mode is sampled with each item as it enters.
module erimm_log_transfer_curve_core #(
   parameter int FRAC_BITS = elt_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_sample_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_inverse_mode
);

   localparam logic [63:0] ONE    = 64'(1) << FRAC_BITS;
   localparam logic [63:0] FRAC_W = 64'(FRAC_BITS) << 56;
   localparam logic [8:0]  SH_TOP = 9'(78 - FRAC_BITS);

   // global pipeline advance
   logic en;

   // config register
   logic mode_ff;

   // input stage
   logic        in_vld_ff;
   logic [31:0] x_ff;
   logic        x_mode_ff;

   // front end decode
   logic [63:0] xu, xs, xc;
   logic [4:0]  p;
   logic        enc_lin, dec_lin;
   logic [63:0] a_op, b_op;
   elt_pkg::ctx_type ctx0;

   // stage chain
   logic             va, vb, ve, vl, vk;
   logic [127:0]     pa, pb, pk;
   elt_pkg::ctx_type ca, cb, ca_in, cb_in, ce, cl, ck;
   logic [63:0]      wp, u;

   // back end
   logic [63:0] y_enc, y_dec, y_lin, y_all;
   logic [8:0]  sh;
   logic [30:0] out_in;

   logic        rsp_valid_ff;
   logic [30:0] rsp_data_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_inverse_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff      <= req_sample_in;
         x_mode_ff <= mode_ff;
      end
   end

   // leading one of the magnitude, only used when x is at least 1 lsb
   always_comb begin
      p = '0;
      for (int i = 0; i < 31; i++) begin
         if (x_ff[i]) begin
            p = 5'(i);
         end
      end
   end

   always_comb begin
      xu = {32'b0, x_ff};
      xs = xu << (64 - FRAC_BITS);
      enc_lin = (xu < ONE) && (xs < elt_pkg::C_ET);
      dec_lin = (xu < ONE) && (xs < elt_pkg::C_XT);
      xc = (xu > ONE) ? ONE : xu;
      ctx0 = '0;
      ctx0.mode = x_mode_ff;
      ctx0.neg  = x_ff[31];
      ctx0.lin  = x_mode_ff ? dec_lin : enc_lin;
      ctx0.p    = p;
      ctx0.m    = xu << (62 - p);
      // encode: linear slope; decode: linear slope or 5.5 log2(10) scale
      a_op = x_mode_ff ? xc : xu;
      if (!x_mode_ff) begin
         b_op = elt_pkg::C_SLOPE;
      end else if (dec_lin) begin
         b_op = elt_pkg::C_ISLOPE;
      end else begin
         b_op = elt_pkg::C_L10X11;
      end
   end

   elt_mul u_mul_a (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(in_vld_ff), .in_a(a_op), .in_b(b_op), .in_ctx(ctx0),
      .out_valid(va), .out_prod(pa), .out_ctx(ca)
   );

   // linear results and split of the exponent into integer and fraction
   always_comb begin
      wp = elt_pkg::shr_round(pa, FRAC_BITS + 1) + (64'(16) << 56) - elt_pkg::C_L10X3;
      ca_in = ca;
      ca_in.res = ca.mode ? elt_pkg::shr_round(pa, 64) : elt_pkg::shr_round(pa, 56);
      ca_in.nb  = wp[63:56];
   end

   elt_mul u_mul_b (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(va), .in_a({2'b0, wp[55:0], 6'b0}), .in_b(elt_pkg::LN2_Q64),
      .in_ctx(ca_in),
      .out_valid(vb), .out_prod(pb), .out_ctx(cb)
   );

   always_comb begin
      cb_in = cb;
      cb_in.t    = pb[127:64];
      cb_in.term = elt_pkg::ONE_Q62;
      cb_in.sum  = elt_pkg::ONE_Q62;
   end

   elt_exp u_exp (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(vb), .in_ctx(cb_in),
      .out_valid(ve), .out_ctx(ce)
   );

   elt_log u_log (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(ve), .in_ctx(ce),
      .out_valid(vl), .out_ctx(cl)
   );

   // log2(x) + 3 log2(10) in q.56, then scaled by 2 / (11 log2(10))
   assign u = (64'(cl.p) << 56) + {8'b0, cl.acc} + elt_pkg::C_L10X3 - FRAC_W;

   elt_mul u_mul_k (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(vl), .in_a(u), .in_b(elt_pkg::C_K1), .in_ctx(cl),
      .out_valid(vk), .out_prod(pk), .out_ctx(ck)
   );

   always_comb begin
      y_enc = elt_pkg::shr_round(pk, 120 - FRAC_BITS);
      if (y_enc > ONE) begin
         y_enc = ONE;
      end
      // 2^n scaling of the exp2 mantissa to the output format
      sh = SH_TOP - {1'b0, ck.nb};
      y_dec = (ck.sum + (64'(1) << (sh[5:0] - 6'd1))) >> sh[5:0];
      y_lin = ck.res;
      if (ck.neg) begin
         y_all = '0;
      end else if (ck.lin) begin
         y_all = y_lin;
      end else if (ck.mode) begin
         y_all = y_dec;
      end else begin
         y_all = y_enc;
      end
      out_in = (y_all > {33'b0, elt_pkg::OUT_MAX}) ? elt_pkg::OUT_MAX : y_all[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vk;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= out_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

`ifndef SYNTHESIS
   // forward curve never exceeds 1.0 before saturation
   a_enc_range: assert property (@(posedge clock) disable iff (reset)
      vk && !ck.neg && !ck.lin && !ck.mode |-> y_enc <= ONE)
      else $error("encode result above 1.0");

   // decode exponent shift stays in the usable range
   a_dec_shift: assert property (@(posedge clock) disable iff (reset)
      vk && !ck.neg && !ck.lin && ck.mode |-> sh >= 9'd1 && sh <= 9'd63)
      else $error("decode shift out of range");

   // a held result stalls the whole pipeline
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out) && $stable(vk))
      else $error("pipeline moved during output stall");

   // negative inputs always land on zero
   a_neg_zero: assert property (@(posedge clock) disable iff (reset)
      vk && en && ck.neg |=> rsp_sample_out == 31'd0)
      else $error("negative input gave nonzero result");
`endif

endmodule
